>>> rtl/core/assert_macros.svh
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/lpot_pkg.sv
// ----------------------------------------------------------------------------
// lpot_pkg
// Types, constants and helper functions of the leg phase oscillator.
// ----------------------------------------------------------------------------
package lpot_pkg;

   // Sizing of the leg phase store.
   localparam int LEGS       = 4;
   localparam int PHASE_BITS = 16;
   localparam int LEG_IDX_W  = (LEGS > 1) ? $clog2(LEGS) : 1;

   // CORDIC datapath sizing.
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int XY_W         = 45;
   localparam int Z_W          = 26;

   // Shared multiplier and accumulator sizing.
   localparam int MUL_A_W = 44;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 52;
   localparam int C_W     = 20;
   localparam int TX_W    = 27;
   localparam int TY_W    = 43;
   localparam int LEN_W   = 36;

   // Fixed constants.
   localparam int CORDIC_GAIN   = 39797;
   localparam int RAD_TO_TURN24 = 2670177;
   localparam int SETTLE        = 16384;
   localparam int HIP_MAX       = 32768;
   localparam int KNEE_MAX      = 65535;
   localparam int KNEE_MIN      = -65536;
   localparam int QUARTER_TURN  = 4194304;
   localparam int HALF_TURN     = 8388608;
   localparam int FULL_TURN     = 16777216;

   // Reset phases, scaled from 16-bit turn units to the phase width.
   localparam logic [PHASE_BITS-1:0] PHASE_EVEN_RST = PHASE_BITS'((PHASE_BITS >= 16) ?
      (64'd19275 << (PHASE_BITS >= 16 ? PHASE_BITS - 16 : 0)) :
      (64'd19275 >> (PHASE_BITS < 16 ? 16 - PHASE_BITS : 0)));
   localparam logic [PHASE_BITS-1:0] PHASE_ODD_RST = PHASE_BITS'((PHASE_BITS >= 16) ?
      (64'd14247 << (PHASE_BITS >= 16 ? PHASE_BITS - 16 : 0)) :
      (64'd14247 >> (PHASE_BITS < 16 ? 16 - PHASE_BITS : 0)));

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_ANGULAR_VELOCITY = 3'd0,
      REG_SUPPORT_GAIN     = 3'd1,
      REG_PROPULSION_GAIN  = 3'd2,
      REG_TIME_STEP        = 3'd3,
      REG_OFFSET_Y         = 3'd4,
      REG_AMP_X            = 3'd5,
      REG_AMP_Y            = 3'd6,
      REG_GROUND_SCALE     = 3'd7
   } lpot_reg_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_ROT_A,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
      ST_ROT_B, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
      ST_VEC, ST_L1, ST_L2
   } lpot_state_type;

   // Control into the CORDIC unit.
   typedef struct packed {
      logic load;
      logic vectoring;
   } lpot_cordic_ctrl_type;

   // Status out of the CORDIC unit.
   typedef struct packed {
      logic busy;
      logic done;
   } lpot_cordic_stat_type;

   // Angle folded into a quarter turn either side of zero.
   typedef struct packed {
      logic                  neg;
      logic signed [Z_W-1:0] z;
   } lpot_fold_type;

   // Arctangent table in units of 2^-24 turn.
   function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         4'd0:    v = Z_W'(2097152);
         4'd1:    v = Z_W'(1238021);
         4'd2:    v = Z_W'(654136);
         4'd3:    v = Z_W'(332050);
         4'd4:    v = Z_W'(166669);
         4'd5:    v = Z_W'(83416);
         4'd6:    v = Z_W'(41718);
         4'd7:    v = Z_W'(20860);
         4'd8:    v = Z_W'(10430);
         4'd9:    v = Z_W'(5215);
         4'd10:   v = Z_W'(2608);
         4'd11:   v = Z_W'(1304);
         4'd12:   v = Z_W'(652);
         4'd13:   v = Z_W'(326);
         4'd14:   v = Z_W'(163);
         default: v = Z_W'(81);
      endcase
      return v;
   endfunction

   // Leg number wrapped onto the stored legs.
   function automatic logic [LEG_IDX_W-1:0] leg_index(input logic [1:0] leg);
      logic [3:0] v;
      v = {2'b00, leg};
      for (int k = 0; k < 3; k++) begin
         if (v >= 4'(LEGS)) begin
            v = v - 4'(LEGS);
         end
      end
      return LEG_IDX_W'(v);
   endfunction

   // Phase to a 24-bit turn angle, folded for the rotation pass.
   function automatic lpot_fold_type fold_phase(input logic [PHASE_BITS-1:0] p);
      lpot_fold_type f;
      logic [23:0]   a;
      a = 24'(p) << (24 - PHASE_BITS);
      f.neg = 1'b0;
      f.z   = $signed({2'b00, a});
      if (a[23]) begin
         f.z = f.z - Z_W'(FULL_TURN);
      end
      if (f.z > Z_W'(QUARTER_TURN)) begin
         f.z   = f.z - Z_W'(HALF_TURN);
         f.neg = 1'b1;
      end else if (f.z < -Z_W'(QUARTER_TURN)) begin
         f.z   = f.z + Z_W'(HALF_TURN);
         f.neg = 1'b1;
      end
      return f;
   endfunction

endpackage

>>> rtl/core/lpot_cordic.sv
// ----------------------------------------------------------------------------
// lpot_cordic
// Shared iterative CORDIC: one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module lpot_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lpot_pkg::lpot_cordic_ctrl_type       ctrl,
   input  logic signed [lpot_pkg::XY_W-1:0]     x_init,
   input  logic signed [lpot_pkg::XY_W-1:0]     y_init,
   input  logic signed [lpot_pkg::Z_W-1:0]      z_init,
   output logic signed [lpot_pkg::XY_W-1:0]     x_out,
   output logic signed [lpot_pkg::XY_W-1:0]     y_out,
   output logic signed [lpot_pkg::Z_W-1:0]      z_out,
   output lpot_pkg::lpot_cordic_stat_type       stat
);
   import lpot_pkg::*;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [Z_W-1:0]  z_ff, z_in, atn;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic                   busy_ff, busy_in, done_ff, done_in, vec_ff, vec_in;
   logic                   dir_pos;

   // One micro-rotation; direction from the angle or from the sign of y.
   always_comb begin
      dx      = x_ff >>> iter_ff;
      dy      = y_ff >>> iter_ff;
      atn     = atan_lut(iter_ff);
      dir_pos = vec_ff ? (y_ff <= 0) : (z_ff >= 0);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      vec_in  = vec_ff;
      done_in = 1'b0;
      if (ctrl.load) begin
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
         iter_in = '0;
         busy_in = 1'b1;
         vec_in  = ctrl.vectoring;
      end else if (busy_ff) begin
         if (dir_pos) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - atn;
         end else begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + atn;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      vec_ff  <= vec_in;
   end

   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> rtl/core/leg_phase_oscillator_target_unit.sv
// ----------------------------------------------------------------------------
// leg_phase_oscillator_target_unit
// Per-leg feedback gait oscillator with foot target, hip angle and knee length.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | direction
//  request  | req_valid req_stall req_leg req_normal_x/_y    | in
//           | req_femur_length                               |
//  response | rsp_valid rsp_stall rsp_leg_out rsp_phase_out  | out
//           | rsp_hip_angle rsp_knee_length                  |
//  csr      | csr_valid csr_ready csr_index csr_data         | in
//
// A transaction makes three 16-step passes through the shared CORDIC unit
// and uses the shared multiplier between them.
// One transaction is in flight at a time; req_stall is high while it runs.
// A finished result sits in the output register, so the next request can be
// taken while the response is stalled; a stalled response holds the final step.
// Reset is synchronous and restores the state, the response valid flag, the configuration registers and the leg phases.
`include "assert_macros.svh"

module leg_phase_oscillator_target_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_leg,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic [15:0]        req_femur_length,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_leg_out,
   output logic [15:0]        rsp_phase_out,
   output logic [15:0]        rsp_hip_angle,
   output logic signed [16:0] rsp_knee_length,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import lpot_pkg::*;

   lpot_state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] omega_ff, sg_ff, pg_ff, dt_ff, offy_ff, ampx_ff, ampy_ff, gs_ff;

   // Transaction payload and working registers.
   logic [PHASE_BITS-1:0]   phase_ff [LEGS];
   logic [PHASE_BITS-1:0]   newp_ff, newp_in;
   logic                    phase_we;
   logic [1:0]              leg_ff, leg_in;
   logic [LEG_IDX_W-1:0]    idx_ff, idx_in;
   logic signed [15:0]      nx_ff, nx_in, ny_ff, ny_in;
   logic [15:0]             femur_ff, femur_in;
   logic signed [C_W-1:0]   c_ff, c_in, s_ff, s_in;
   logic                    neg_ff, neg_in, zero_ff, zero_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [TX_W-1:0]   tx_ff, tx_in;
   logic signed [TY_W-1:0]   ty_ff, ty_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_leg_ff, rsp_leg_in;
   logic [15:0]        rsp_phase_ff, rsp_phase_in, rsp_hip_ff, rsp_hip_in;
   logic signed [16:0] rsp_knee_ff, rsp_knee_in;

   // Shared multiplier operands.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_en;

   // Rounded views of the product and accumulator.
   logic signed [PROD_W-1:0]  prod_r8, prod_r16, prod_r24, prod_dsum;
   logic signed [ACC_W-1:0]   acc_r8;
   logic [PHASE_BITS-1:0]     delta;
   logic signed [TY_W-1:0]    ty_abs;
   logic signed [LEN_W-1:0]   len_w, knee_w;
   logic signed [Z_W-1:0]     hip_w;
   lpot_fold_type             fold;

   // CORDIC connection.
   lpot_cordic_ctrl_type      cordic_ctrl;
   lpot_cordic_stat_type      cordic_stat;
   logic signed [XY_W-1:0]    cx_init, cy_init, cx_out, cy_out;
   logic signed [Z_W-1:0]     cz_init, cz_out;

   lpot_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cordic_ctrl),
      .x_init (cx_init),
      .y_init (cy_init),
      .z_init (cz_init),
      .x_out  (cx_out),
      .y_out  (cy_out),
      .z_out  (cz_out),
      .stat   (cordic_stat)
   );

   // Rounding helpers: add half an LSB, then shift arithmetically.
   always_comb begin
      prod_r8   = (prod_ff + PROD_W'(128)) >>> 8;
      prod_r16  = (prod_ff + PROD_W'(32768)) >>> 16;
      prod_r24  = (prod_ff + PROD_W'(8388608)) >>> 24;
      prod_dsum = prod_ff + (PROD_W'(1) <<< (47 - PHASE_BITS));
      delta     = prod_dsum[47 -: PHASE_BITS];
      acc_r8    = (acc_ff + ACC_W'(128)) >>> 8;
      ty_abs    = ty_ff[TY_W-1] ? -ty_ff : ty_ff;
      fold      = fold_phase(state_ff == ST_LOAD ? phase_ff[idx_ff] : newp_in);
      len_w     = LEN_W'(prod_r24);
      knee_w    = len_w - LEN_W'($signed({1'b0, femur_ff}));
      hip_w     = ((cz_out + Z_W'(128)) >>> 8) + Z_W'(SETTLE);
   end

   // Sequencer: next state, multiplier operands and working registers.
   always_comb begin
      state_in     = state_ff;
      leg_in       = leg_ff;
      idx_in       = idx_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      femur_in     = femur_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      newp_in      = newp_ff;
      phase_we     = 1'b0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      cordic_ctrl  = '0;
      cx_init      = XY_W'(CORDIC_GAIN);
      cy_init      = '0;
      cz_init      = fold.z;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_leg_in   = rsp_leg_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_hip_in   = rsp_hip_ff;
      rsp_knee_in  = rsp_knee_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               leg_in   = req_leg;
               idx_in   = leg_index(req_leg);
               nx_in    = req_normal_x;
               ny_in    = req_normal_y;
               femur_in = req_femur_length;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cordic_ctrl.load = 1'b1;
            neg_in           = fold.neg;
            state_in         = ST_ROT_A;
         end
         ST_ROT_A, ST_ROT_B: begin
            if (cordic_stat.done) begin
               c_in     = neg_ff ? C_W'(-cx_out) : C_W'(cx_out);
               s_in     = neg_ff ? C_W'(-cy_out) : C_W'(cy_out);
               state_in = (state_ff == ST_ROT_A) ? ST_M1 : ST_T1;
            end
         end
         // Rate terms: sg*Ny*c and pg*Nx*c.
         ST_M1: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'($signed({1'b0, sg_ff}));
            mul_b    = MUL_B_W'(ny_ff);
            state_in = ST_M2;
         end
         ST_M2: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(prod_ff);
            mul_b    = MUL_B_W'(c_ff);
            state_in = ST_M3;
         end
         ST_M3: begin
            acc_in   = (ACC_W'($signed(omega_ff)) <<< 24) - ACC_W'(prod_ff);
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'($signed({1'b0, pg_ff}));
            mul_b    = MUL_B_W'(nx_ff);
            state_in = ST_M4;
         end
         ST_M4: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(prod_ff);
            mul_b    = MUL_B_W'(c_ff);
            state_in = ST_M5;
         end
         ST_M5: begin
            acc_in   = acc_ff - ACC_W'(prod_ff);
            state_in = ST_M6;
         end
         // Scale by the time step, then convert radians to turns.
         ST_M6: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(acc_r8);
            mul_b    = MUL_B_W'($signed({1'b0, dt_ff}));
            state_in = ST_M7;
         end
         ST_M7: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(prod_r16);
            mul_b    = MUL_B_W'(RAD_TO_TURN24);
            state_in = ST_M8;
         end
         ST_M8: begin
            newp_in          = phase_ff[idx_ff] + delta;
            phase_we         = 1'b1;
            cordic_ctrl.load = 1'b1;
            neg_in           = fold.neg;
            state_in         = ST_ROT_B;
         end
         // Foot target from the new phase.
         ST_T1: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'($signed({1'b0, ampx_ff}));
            mul_b    = MUL_B_W'(c_ff);
            state_in = ST_T2;
         end
         ST_T2: begin
            tx_in    = TX_W'(prod_r8);
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'($signed({1'b0, ampy_ff}));
            mul_b    = (s_ff > 0) ? MUL_B_W'(256) : MUL_B_W'($signed({1'b0, gs_ff}));
            state_in = ST_T3;
         end
         ST_T3: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(prod_ff);
            mul_b    = MUL_B_W'(s_ff);
            state_in = ST_T4;
         end
         ST_T4: begin
            ty_in    = (TY_W'($signed({1'b0, offy_ff})) <<< 24) + TY_W'(prod_r16);
            state_in = ST_T5;
         end
         ST_T5: begin
            zero_in               = (tx_ff == 0) && (ty_ff == 0);
            cordic_ctrl.load      = 1'b1;
            cordic_ctrl.vectoring = 1'b1;
            cx_init               = XY_W'(ty_abs);
            cy_init               = XY_W'(tx_ff);
            cz_init               = '0;
            state_in              = ST_VEC;
         end
         ST_VEC: begin
            if (cordic_stat.done) begin
               state_in = ST_L1;
            end
         end
         ST_L1: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(cx_out);
            mul_b    = MUL_B_W'(CORDIC_GAIN);
            state_in = ST_L2;
         end
         // Final step: wait for a free output register.
         ST_L2: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_leg_in   = leg_ff;
               rsp_phase_in = 16'({newp_ff, 16'b0} >> PHASE_BITS);
               if (zero_ff) begin
                  rsp_hip_in = 16'(SETTLE);
               end else if (hip_w < 0) begin
                  rsp_hip_in = '0;
               end else if (hip_w > Z_W'(HIP_MAX)) begin
                  rsp_hip_in = 16'(HIP_MAX);
               end else begin
                  rsp_hip_in = 16'(hip_w);
               end
               if (knee_w > LEN_W'(KNEE_MAX)) begin
                  rsp_knee_in = 17'(KNEE_MAX);
               end else if (knee_w < LEN_W'(KNEE_MIN)) begin
                  rsp_knee_in = 17'(KNEE_MIN);
               end else begin
                  rsp_knee_in = 17'(knee_w);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      prod_in = mul_en ? PROD_W'(mul_a * mul_b) : prod_ff;
   end

   // Control state, configuration registers and leg phases.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         omega_ff     <= 16'd0;
         sg_ff        <= 16'd128;
         pg_ff        <= 16'd0;
         dt_ff        <= 16'd66;
         offy_ff      <= 16'd5243;
         ampx_ff      <= 16'd1311;
         ampy_ff      <= 16'd1049;
         gs_ff        <= 16'd256;
         for (int k = 0; k < LEGS; k++) begin
            phase_ff[k] <= (k % 2 == 1) ? PHASE_ODD_RST : PHASE_EVEN_RST;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (phase_we) begin
            phase_ff[idx_ff] <= newp_in;
         end
         if (csr_valid) begin
            unique case (lpot_reg_type'(csr_index))
               REG_ANGULAR_VELOCITY: omega_ff <= csr_data;
               REG_SUPPORT_GAIN:     sg_ff    <= csr_data;
               REG_PROPULSION_GAIN:  pg_ff    <= csr_data;
               REG_TIME_STEP:        dt_ff    <= csr_data;
               REG_OFFSET_Y:         offy_ff  <= csr_data;
               REG_AMP_X:            ampx_ff  <= csr_data;
               REG_AMP_Y:            ampy_ff  <= csr_data;
               REG_GROUND_SCALE:     gs_ff    <= csr_data;
               default:              ;
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      leg_ff       <= leg_in;
      idx_ff       <= idx_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      femur_ff     <= femur_in;
      c_ff         <= c_in;
      s_ff         <= s_in;
      neg_ff       <= neg_in;
      zero_ff      <= zero_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      newp_ff      <= newp_in;
      rsp_leg_ff   <= rsp_leg_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_hip_ff   <= rsp_hip_in;
      rsp_knee_ff  <= rsp_knee_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_leg_out     = rsp_leg_ff;
   assign rsp_phase_out   = rsp_phase_ff;
   assign rsp_hip_angle   = rsp_hip_ff;
   assign rsp_knee_length = rsp_knee_ff;

   // An accepted transaction starts the phase load on the next cycle.
   `ASSERT_CLK(a_accept_loads, (req_valid && !req_stall) |=> (state_ff == ST_LOAD), "accept did not start a load")
   // The CORDIC only finishes while the sequencer waits for it.
   `ASSERT_IMPLY(a_done_in_wait, cordic_stat.done, (state_ff == ST_ROT_A) || (state_ff == ST_ROT_B) || (state_ff == ST_VEC), "CORDIC finished outside a wait state")
   // The hip angle stays within a half turn.
   `ASSERT_IMPLY(a_hip_range, rsp_valid, rsp_hip_angle <= 16'(HIP_MAX), "hip angle out of range")

endmodule
